// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define CHR_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition must hold in the cycle after the trigger.
`define CHR_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/chr_pkg.sv -----
package chr_pkg;

	// default sizes
	localparam int DefMaxPoints   = 256;
	localparam int DefMaxMembers  = 16;
	localparam int DefMaxReplicas = 8;

	// hash constants
	localparam logic [63:0] HASH_SEED  = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [63:0] MIX_C1     = 64'hff51_afd7_ed55_8ccd;
	localparam logic [63:0] MIX_C2     = 64'hc4ce_b9fe_1a85_ec53;
	localparam logic [63:0] ABSORB_ADD = 64'h0000_0000_52dc_e729;
	localparam int          MIX_SHIFT  = 33;
	localparam int          ROT_LEFT   = 27;

	// ASCII used when building point names
	localparam logic [7:0] CHAR_COLON = 8'h3a;
	localparam logic [3:0] CHAR_DIGIT_HI = 4'h3;

	// register reset values, and the vnode count used when the register is zero
	localparam logic [6:0] VNODES_RESET  = 7'd16;
	localparam logic [6:0] VNODES_ZERO   = 7'd16;
	localparam logic [3:0] REPLICA_RESET = 4'd3;

	// stream layout: node_id, key_word, key_bytes, max_wanted
	localparam int S_DATA_W = 104;

	typedef enum logic [1:0] {
		CFG_VNODES   = 2'd0,
		CFG_REPLICAS = 2'd1
	} cfg_index_t;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_KEY    = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EXISTS    = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	// request to and answer from the mixer
	typedef struct packed {
		logic        start;
		logic [63:0] k;
	} mix_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] value;
	} mix_rsp_t;

	// ring table entry
	typedef struct packed {
		logic [31:0] owner;
		logic [63:0] hash;
	} pt_entry_t;

endpackage

// ----- rtl/chr_mix.sv -----
// 64-bit finaliser mix on one shared 32x32 multiplier.
// Each 64x64 low product takes three partial products.
module chr_mix import chr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mix_req_t req,
	output mix_rsp_t rsp
);

	typedef enum logic [1:0] {M_IDLE, M_MUL, M_XOR} mstate_t;

	mstate_t     state_q;
	logic [1:0]  step_q;
	logic        pass_q;
	logic        done_q;
	logic [63:0] x_q;
	logic [63:0] acc_q;
	logic [63:0] mconst;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod;

	// operand select for the partial products
	always_comb begin
		mconst = pass_q ? MIX_C2 : MIX_C1;
		unique case (step_q)
			2'd0: begin
				op_a = x_q[31:0];
				op_b = mconst[31:0];
			end
			2'd1: begin
				op_a = x_q[31:0];
				op_b = mconst[63:32];
			end
			default: begin
				op_a = x_q[63:32];
				op_b = mconst[31:0];
			end
		endcase
		prod = 64'(op_a) * 64'(op_b);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			step_q  <= '0;
			pass_q  <= 1'b0;
			done_q  <= 1'b0;
			x_q     <= '0;
			acc_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (req.start) begin
						x_q     <= req.k ^ (req.k >> MIX_SHIFT);
						pass_q  <= 1'b0;
						step_q  <= '0;
						state_q <= M_MUL;
					end
				end
				M_MUL: begin
					if (step_q == 2'd0) begin
						acc_q  <= prod;
						step_q <= step_q + 2'd1;
					end else begin
						acc_q <= acc_q + {prod[31:0], 32'h0};
						if (step_q == 2'd1) begin
							step_q <= step_q + 2'd1;
						end else begin
							state_q <= M_XOR;
						end
					end
				end
				M_XOR: begin
					x_q <= acc_q ^ (acc_q >> MIX_SHIFT);
					if (pass_q) begin
						done_q  <= 1'b1;
						state_q <= M_IDLE;
					end else begin
						pass_q  <= 1'b1;
						step_q  <= '0;
						state_q <= M_MUL;
					end
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign rsp = '{done: done_q, value: x_q};

endmodule

// ----- rtl/consistent_hash_ring.sv -----
// Channel   Dir  Handshake           Payload
// cfg       in   cfg_valid/ready     cfg_index, cfg_data
// s         in   s_tvalid/tready     s_tdata, s_tuser (action), s_tlast (key_last)
// m         out  m_tvalid/tready     m_tdata, m_tuser (status), m_tlast (last)
//
// One item at a time; every hash goes through the one mixer.
// Key word: one mix; the last word adds a final mix, a binary search over
// the table, a walk over its points and result words for the owners found.
// Add: decimal conversion of the node id, then per point 2 to 3 mixes and
// a shift of each larger table entry. Remove: one pass over the table.
// Reset clears counts, resets registers and key accumulator; tables stay.
// A held result on m stalls the next result, which then blocks further input.
`include "assert_macros.svh"
module consistent_hash_ring import chr_pkg::*; #(
	parameter  int MAX_POINTS   = DefMaxPoints,
	parameter  int MAX_MEMBERS  = DefMaxMembers,
	parameter  int MAX_REPLICAS = DefMaxReplicas,
	localparam int CNTW  = $clog2(MAX_MEMBERS + 1),
	localparam int OUT_W = ((32 + CNTW + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [6:0]          cfg_data,
	input  logic                s_tvalid,
	output logic                s_tready,
	// node_id[31:0], key_word[95:32], key_bytes[99:96], max_wanted[103:100]
	input  logic [S_DATA_W-1:0] s_tdata,
	// action[1:0]
	input  logic [1:0]          s_tuser,
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	// replica_node[31:0], ring member count above it, zero fill
	output logic [OUT_W-1:0]    m_tdata,
	// status[2:0]
	output logic [2:0]          m_tuser,
	output logic                m_tlast
);

	localparam int PW  = $clog2(MAX_POINTS);
	localparam int PCW = $clog2(MAX_POINTS + 1);
	localparam int MW  = $clog2(MAX_MEMBERS);
	localparam int RW  = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
	localparam int RCW = $clog2(MAX_REPLICAS + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_SCAN, S_CONV, S_NDIG, S_COLON, S_IDIG, S_HW0, S_HW1, S_HFIN,
		S_INS_RD, S_INS_CMP, S_REM_RD, S_REM_CHK, S_KMIX, S_KFIN,
		S_SRCH_RD, S_SRCH_CMP, S_WALK_RD, S_WALK_CHK, S_EMIT_ONE, S_EMIT_LK
	} state_t;

	function automatic logic [63:0] byte_mask(input logic [3:0] n);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (4'(b) < n) m[8*b +: 8] = 8'hff;
		end
		return m;
	endfunction

	function automatic logic [63:0] absorb(input logic [63:0] h, input logic [63:0] r);
		logic [63:0] x;
		x = h ^ r;
		x = {x[63-ROT_LEFT:0], x[63:64-ROT_LEFT]};
		return (x << 2) + x + ABSORB_ADD;
	endfunction

	function automatic logic [11:0] bcd3_inc(input logic [11:0] b);
		logic [11:0] o;
		o = b;
		if (b[3:0] != 4'd9) begin
			o[3:0] = b[3:0] + 4'd1;
		end else begin
			o[3:0] = 4'd0;
			if (b[7:4] != 4'd9) begin
				o[7:4] = b[7:4] + 4'd1;
			end else begin
				o[7:4]  = 4'd0;
				o[11:8] = b[11:8] + 4'd1;
			end
		end
		return o;
	endfunction

	state_t          state_q;
	logic [6:0]      vnodes_q;
	logic [3:0]      repl_q;
	logic [PCW-1:0]  pcount_q;
	logic [CNTW-1:0] mcount_q;
	logic [63:0]     acc_q;
	logic            mbusy_q;
	status_t         st_q;

	// captured item
	action_t         act_q;
	logic [31:0]     node_q;
	logic [63:0]     word_q;
	logic [3:0]      kbytes_q;
	logic            klast_q;
	logic            kfull_q;
	logic [3:0]      mw_q;

	// point naming and hashing
	logic [CNTW-1:0] mi_q;
	logic [31:0]     sh_q;
	logic [39:0]     bcd_q;
	logic [4:0]      dd_q;
	logic [3:0]      di_q;
	logic            nz_q;
	logic [127:0]    text_q;
	logic [3:0]      tpos_q;
	logic [3:0]      nlen_q;
	logic [6:0]      vi_q;
	logic [11:0]     vb_q;
	logic [63:0]     ph_q;
	logic [63:0]     newh_q;
	logic [PCW-1:0]  pos_q;

	// remove, search and walk
	logic [PCW-1:0]  ri_q;
	logic [PCW-1:0]  w_q;
	logic [63:0]     h_q;
	logic [PCW-1:0]  lo_q;
	logic [PCW-1:0]  hi_q;
	logic [PCW-1:0]  mid_q;
	logic [PCW-1:0]  wi_q;
	logic [RCW-1:0]  cnt_q;
	logic [RCW-1:0]  tgt_q;
	logic [RCW-1:0]  ej_q;

	// output register
	logic            m_tvalid_q;
	logic [2:0]      o_status_q;
	logic [31:0]     o_node_q;
	logic [CNTW-1:0] o_count_q;
	logic            o_last_q;

	// storage
	pt_entry_t       pt_mem [MAX_POINTS];
	pt_entry_t       rdata_q;
	logic [31:0]     members_q [MAX_MEMBERS];
	logic [31:0]     chosen_q [MAX_REPLICAS];

	mix_req_t        mix_req;
	mix_rsp_t        mix_rsp;

	logic            accept;
	logic            out_free;
	logic            emit_go;
	logic [6:0]      vn;
	logic            full;
	logic            last_pt;
	logic [39:0]     bcd_adj;
	logic [3:0]      ndig;
	logic [3:0]      idig;
	logic            in_kfull;
	logic [RCW-1:0]  tgt;
	logic [31:0]     r_eff;
	logic [31:0]     t_lim;
	logic [PCW-1:0]  pos_m1;
	logic [PCW:0]    mid_sum;
	logic [PCW-1:0]  mid;
	logic [PCW:0]    wsum;
	logic [PCW:0]    widx;
	logic [CNTW-1:0] mlast;
	logic            mem_we;
	logic [PW-1:0]   mem_wa;
	logic [PW-1:0]   mem_ra;
	pt_entry_t       mem_wd;
	logic            mb_we;
	logic [MW-1:0]   mb_wa;
	logic [31:0]     mb_wd;
	logic            dup;
	logic            mstate;
	logic [RCW-1:0]  ej_n;

	chr_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mix_req),
		.rsp    (mix_rsp)
	);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign emit_go   = out_free && ((state_q == S_EMIT_ONE) || (state_q == S_EMIT_LK));
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = OUT_W'({o_count_q, o_node_q});
	assign m_tuser   = o_status_q;
	assign m_tlast   = o_last_q;

	// working values
	always_comb begin
		vn   = (vnodes_q == '0) ? VNODES_ZERO : vnodes_q;
		full = (32'(mcount_q) >= 32'(MAX_MEMBERS)) ||
			(32'(pcount_q) + 32'(vn) > 32'(MAX_POINTS));
		last_pt = ((vi_q + 7'd1) == vn);
		for (int d = 0; d < 10; d++) begin
			bcd_adj[4*d +: 4] = (bcd_q[4*d +: 4] >= 4'd5) ?
				bcd_q[4*d +: 4] + 4'd3 : bcd_q[4*d +: 4];
		end
		ndig     = bcd_q[{di_q, 2'b00} +: 4];
		idig     = vb_q[{di_q[1:0], 2'b00} +: 4];
		in_kfull = !s_tlast || (s_tdata[99:96] >= 4'd8);
		// replica target
		r_eff = (repl_q == '0) ? 32'd1 :
			(32'(repl_q) > 32'(MAX_REPLICAS)) ? 32'(MAX_REPLICAS) : 32'(repl_q);
		t_lim = r_eff;
		if (32'(mw_q) < t_lim) t_lim = 32'(mw_q);
		if (32'(mcount_q) < t_lim) t_lim = 32'(mcount_q);
		tgt     = RCW'(t_lim);
		pos_m1  = pos_q - 1'b1;
		mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
		mid     = mid_sum[PCW:1];
		wsum    = {1'b0, lo_q} + {1'b0, wi_q};
		widx    = (wsum >= {1'b0, pcount_q}) ? wsum - {1'b0, pcount_q} : wsum;
		mlast   = mcount_q - 1'b1;
		ej_n    = ej_q + 1'b1;
		dup = 1'b0;
		for (int j = 0; j < MAX_REPLICAS; j++) begin
			if ((32'(j) < 32'(cnt_q)) && (chosen_q[j] == rdata_q.owner)) dup = 1'b1;
		end
	end

	// mixer requests
	always_comb begin
		mstate = (state_q == S_HW0) || (state_q == S_HW1) || (state_q == S_HFIN) ||
			(state_q == S_KMIX) || (state_q == S_KFIN);
		mix_req.start = mstate && !mbusy_q;
		unique case (state_q)
			S_HW0:   mix_req.k = (tpos_q < 4'd8) ?
				text_q[63:0] & byte_mask(tpos_q) : text_q[63:0];
			S_HW1:   mix_req.k = text_q[127:64] & byte_mask(tpos_q - 4'd8);
			S_HFIN:  mix_req.k = ph_q;
			S_KMIX:  mix_req.k = kfull_q ? word_q : word_q & byte_mask(kbytes_q);
			S_KFIN:  mix_req.k = acc_q;
			default: mix_req.k = '0;
		endcase
	end

	// table and member ports
	always_comb begin
		mem_we = 1'b0;
		mem_wa = pos_q[PW-1:0];
		mem_wd = '{owner: node_q, hash: newh_q};
		mem_ra = '0;
		mb_we  = 1'b0;
		mb_wa  = mcount_q[MW-1:0];
		mb_wd  = node_q;
		unique case (state_q)
			S_INS_RD: begin
				mem_ra = pos_m1[PW-1:0];
				mem_we = (pos_q == '0);
			end
			S_INS_CMP: begin
				mem_we = 1'b1;
				if (rdata_q.hash > newh_q) mem_wd = rdata_q;
			end
			S_REM_RD:   mem_ra = ri_q[PW-1:0];
			S_REM_CHK: begin
				mem_we = (rdata_q.owner != node_q);
				mem_wa = w_q[PW-1:0];
				mem_wd = rdata_q;
			end
			S_SRCH_RD:  mem_ra = mid[PW-1:0];
			S_WALK_RD:  mem_ra = widx[PW-1:0];
			S_SCAN: begin
				if (mi_q == mcount_q) begin
					mb_we = (act_q == ACT_ADD) && !full;
				end else if (members_q[mi_q[MW-1:0]] == node_q && act_q == ACT_REMOVE) begin
					mb_we = 1'b1;
					mb_wa = mi_q[MW-1:0];
					mb_wd = members_q[mlast[MW-1:0]];
				end
			end
			default: ;
		endcase
	end

	// ring table memory
	always_ff @(posedge clk) begin
		if (mem_we) pt_mem[mem_wa] <= mem_wd;
		rdata_q <= pt_mem[mem_ra];
	end

	// member list
	always_ff @(posedge clk) begin
		if (mb_we) members_q[mb_wa] <= mb_wd;
	end

	// owners collected by the walk
	always_ff @(posedge clk) begin
		if (state_q == S_WALK_CHK && !dup) chosen_q[cnt_q[RW-1:0]] <= rdata_q.owner;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			vnodes_q   <= VNODES_RESET;
			repl_q     <= REPLICA_RESET;
			pcount_q   <= '0;
			mcount_q   <= '0;
			acc_q      <= HASH_SEED;
			mbusy_q    <= 1'b0;
			st_q       <= ST_OK;
			act_q      <= ACT_NONE;
			node_q     <= '0;
			word_q     <= '0;
			kbytes_q   <= '0;
			klast_q    <= 1'b0;
			kfull_q    <= 1'b0;
			mw_q       <= '0;
			mi_q       <= '0;
			sh_q       <= '0;
			bcd_q      <= '0;
			dd_q       <= '0;
			di_q       <= '0;
			nz_q       <= 1'b0;
			text_q     <= '0;
			tpos_q     <= '0;
			nlen_q     <= '0;
			vi_q       <= '0;
			vb_q       <= '0;
			ph_q       <= '0;
			newh_q     <= '0;
			pos_q      <= '0;
			ri_q       <= '0;
			w_q        <= '0;
			h_q        <= '0;
			lo_q       <= '0;
			hi_q       <= '0;
			mid_q      <= '0;
			wi_q       <= '0;
			cnt_q      <= '0;
			tgt_q      <= '0;
			ej_q       <= '0;
			m_tvalid_q <= 1'b0;
			o_status_q <= '0;
			o_node_q   <= '0;
			o_count_q  <= '0;
			o_last_q   <= 1'b0;
		end else begin
			// register writes
			if (cfg_valid) begin
				unique case (cfg_index_t'(cfg_index))
					CFG_VNODES:   vnodes_q <= cfg_data;
					CFG_REPLICAS: repl_q   <= cfg_data[3:0];
					default: ;
				endcase
			end

			// output word loads or drains
			if (emit_go) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;

			// mixer handshake
			if (mix_req.start) mbusy_q <= 1'b1;
			else if (mix_rsp.done) mbusy_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						act_q    <= action_t'(s_tuser);
						node_q   <= s_tdata[31:0];
						word_q   <= s_tdata[95:32];
						kbytes_q <= s_tdata[99:96];
						mw_q     <= s_tdata[103:100];
						klast_q  <= s_tlast;
						kfull_q  <= in_kfull;
						mi_q     <= '0;
						unique case (action_t'(s_tuser))
							ACT_ADD, ACT_REMOVE: state_q <= S_SCAN;
							ACT_KEY: begin
								if (!in_kfull && s_tdata[99:96] == '0) state_q <= S_KFIN;
								else state_q <= S_KMIX;
							end
							default: ;
						endcase
					end
				end

				// look the node up in the member list
				S_SCAN: begin
					if (mi_q == mcount_q) begin
						if (act_q == ACT_ADD) begin
							if (full) begin
								st_q    <= ST_FULL;
								state_q <= S_EMIT_ONE;
							end else begin
								mcount_q <= mcount_q + 1'b1;
								sh_q     <= node_q;
								bcd_q    <= '0;
								dd_q     <= '0;
								text_q   <= '0;
								state_q  <= S_CONV;
							end
						end else begin
							st_q    <= ST_NOT_FOUND;
							state_q <= S_EMIT_ONE;
						end
					end else if (members_q[mi_q[MW-1:0]] == node_q) begin
						if (act_q == ACT_ADD) begin
							st_q    <= ST_EXISTS;
							state_q <= S_EMIT_ONE;
						end else begin
							mcount_q <= mlast;
							ri_q     <= '0;
							w_q      <= '0;
							state_q  <= S_REM_RD;
						end
					end else begin
						mi_q <= mi_q + 1'b1;
					end
				end

				// node id to decimal, one bit a cycle
				S_CONV: begin
					bcd_q <= {bcd_adj[38:0], sh_q[31]};
					sh_q  <= sh_q << 1;
					dd_q  <= dd_q + 5'd1;
					if (dd_q == 5'd31) begin
						di_q    <= 4'd9;
						nz_q    <= 1'b0;
						tpos_q  <= '0;
						state_q <= S_NDIG;
					end
				end

				// node digits into the name, leading zeros dropped
				S_NDIG: begin
					if (ndig != 4'd0 || nz_q || di_q == 4'd0) begin
						text_q[{tpos_q, 3'b000} +: 8] <= {CHAR_DIGIT_HI, ndig};
						tpos_q <= tpos_q + 4'd1;
						nz_q   <= 1'b1;
					end
					if (di_q == 4'd0) begin
						nlen_q  <= tpos_q + 4'd1;
						vi_q    <= '0;
						vb_q    <= '0;
						state_q <= S_COLON;
					end else begin
						di_q <= di_q - 4'd1;
					end
				end

				S_COLON: begin
					text_q[{nlen_q, 3'b000} +: 8] <= CHAR_COLON;
					tpos_q  <= nlen_q + 4'd1;
					di_q    <= 4'd2;
					nz_q    <= 1'b0;
					state_q <= S_IDIG;
				end

				// point index digits
				S_IDIG: begin
					if (idig != 4'd0 || nz_q || di_q == 4'd0) begin
						text_q[{tpos_q, 3'b000} +: 8] <= {CHAR_DIGIT_HI, idig};
						tpos_q <= tpos_q + 4'd1;
						nz_q   <= 1'b1;
					end
					if (di_q == 4'd0) state_q <= S_HW0;
					else di_q <= di_q - 4'd1;
				end

				// hash of the name
				S_HW0: begin
					if (mix_rsp.done) begin
						ph_q <= (tpos_q >= 4'd8) ? absorb(HASH_SEED, mix_rsp.value) :
							HASH_SEED ^ mix_rsp.value;
						state_q <= (tpos_q > 4'd8) ? S_HW1 : S_HFIN;
					end
				end
				S_HW1: begin
					if (mix_rsp.done) begin
						ph_q    <= ph_q ^ mix_rsp.value;
						state_q <= S_HFIN;
					end
				end
				S_HFIN: begin
					if (mix_rsp.done) begin
						newh_q  <= mix_rsp.value;
						pos_q   <= pcount_q;
						state_q <= S_INS_RD;
					end
				end

				// sorted insert, shifting larger hashes up
				S_INS_RD: begin
					if (pos_q == '0) begin
						pcount_q <= pcount_q + 1'b1;
						if (last_pt) begin
							st_q    <= ST_OK;
							state_q <= S_EMIT_ONE;
						end else begin
							vi_q    <= vi_q + 7'd1;
							vb_q    <= bcd3_inc(vb_q);
							state_q <= S_COLON;
						end
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (rdata_q.hash > newh_q) begin
						pos_q   <= pos_m1;
						state_q <= S_INS_RD;
					end else begin
						pcount_q <= pcount_q + 1'b1;
						if (last_pt) begin
							st_q    <= ST_OK;
							state_q <= S_EMIT_ONE;
						end else begin
							vi_q    <= vi_q + 7'd1;
							vb_q    <= bcd3_inc(vb_q);
							state_q <= S_COLON;
						end
					end
				end

				// compaction on remove
				S_REM_RD: begin
					if (ri_q == pcount_q) begin
						pcount_q <= w_q;
						st_q     <= ST_OK;
						state_q  <= S_EMIT_ONE;
					end else begin
						state_q <= S_REM_CHK;
					end
				end
				S_REM_CHK: begin
					if (rdata_q.owner != node_q) w_q <= w_q + 1'b1;
					ri_q    <= ri_q + 1'b1;
					state_q <= S_REM_RD;
				end

				// key word into the accumulator
				S_KMIX: begin
					if (mix_rsp.done) begin
						acc_q   <= kfull_q ? absorb(acc_q, mix_rsp.value) : acc_q ^ mix_rsp.value;
						state_q <= klast_q ? S_KFIN : S_IDLE;
					end
				end
				S_KFIN: begin
					if (mix_rsp.done) begin
						h_q   <= mix_rsp.value;
						acc_q <= HASH_SEED;
						tgt_q <= tgt;
						lo_q  <= '0;
						hi_q  <= pcount_q;
						if (pcount_q == '0) begin
							st_q    <= ST_EMPTY;
							state_q <= S_EMIT_ONE;
						end else if (tgt == '0) begin
							st_q    <= ST_OK;
							state_q <= S_EMIT_ONE;
						end else begin
							state_q <= S_SRCH_RD;
						end
					end
				end

				// binary search for the first hash at or above the key
				S_SRCH_RD: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= S_SRCH_CMP;
					end else begin
						if (lo_q >= pcount_q) lo_q <= '0;
						wi_q    <= '0;
						cnt_q   <= '0;
						state_q <= S_WALK_RD;
					end
				end
				S_SRCH_CMP: begin
					if (rdata_q.hash < h_q) lo_q <= mid_q + 1'b1;
					else hi_q <= mid_q;
					state_q <= S_SRCH_RD;
				end

				// clockwise walk for distinct owners
				S_WALK_RD: begin
					if (wi_q == pcount_q || cnt_q == tgt_q) begin
						ej_q    <= '0;
						state_q <= S_EMIT_LK;
					end else begin
						state_q <= S_WALK_CHK;
					end
				end
				S_WALK_CHK: begin
					if (!dup) cnt_q <= cnt_q + 1'b1;
					wi_q    <= wi_q + 1'b1;
					state_q <= S_WALK_RD;
				end

				S_EMIT_ONE: begin
					if (out_free) begin
						o_status_q <= st_q;
						o_node_q   <= '0;
						o_count_q  <= mcount_q;
						o_last_q   <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				S_EMIT_LK: begin
					if (out_free) begin
						o_status_q <= ST_OK;
						o_node_q   <= chosen_q[ej_q[RW-1:0]];
						o_count_q  <= mcount_q;
						o_last_q   <= (ej_n == cnt_q);
						ej_q       <= ej_n;
						if (ej_n == cnt_q) state_q <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	`CHR_ASSERT_NOW(a_pcount_bound, clk, arst_n, 1'b1, pcount_q <= PCW'(MAX_POINTS), "point count beyond table")
	`CHR_ASSERT_NOW(a_err_final, clk, arst_n, m_tvalid && (m_tuser != ST_OK), m_tlast, "error result not final")
	`CHR_ASSERT_NEXT(a_busy_after_edit, clk, arst_n, s_tvalid && s_tready && (s_tuser == ACT_ADD || s_tuser == ACT_REMOVE), !s_tready, "ready after add or remove")
	`CHR_ASSERT_NOW(a_mixer_quiet, clk, arst_n, s_tready, !mbusy_q, "mixer busy while idle")

endmodule

// ----- tb/sv/chr_ring_checker.sv -----
`timescale 1ns / 100ps
// Watches the config, input and result channels of the ring, keeps its own
// copy of the ring table and compares every result word in order.
module chr_ring_checker import chr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [6:0]   cfg_data,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [103:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [39:0]  m_tdata,
	input  logic [2:0]   m_tuser,
	input  logic         m_tlast,
	output int           fail_count,
	output int           pending
);

	typedef struct {
		status_t     st;
		logic [31:0] node;
		logic [4:0]  cnt;
		logic        last;
	} ring_answer_t;

	ring_answer_t answers_due[$];

	logic [63:0] ring_hash [DefMaxPoints];
	logic [31:0] ring_owner[DefMaxPoints];
	int          ring_points;
	logic [31:0] members[DefMaxMembers];
	int          member_num;
	logic [63:0] key_acc;
	logic [6:0]  vnodes;
	logic [3:0]  replicas;

	function automatic logic [63:0] mix64(logic [63:0] k);
		k = k ^ (k >> MIX_SHIFT);
		k = k * 64'hff51afd7ed558ccd;
		k = k ^ (k >> MIX_SHIFT);
		k = k * 64'hc4ceb9fe1a85ec53;
		k = k ^ (k >> MIX_SHIFT);
		return k;
	endfunction

	function automatic logic [63:0] absorb(logic [63:0] h, logic [63:0] k);
		h = h ^ mix64(k);
		h = {h[36:0], h[63:37]};
		return h * 64'd5 + 64'h52dce729;
	endfunction

	// hash of the text "node:idx"
	function automatic logic [63:0] vpoint_hash(logic [31:0] node, int idx);
		logic [7:0]  txt[24];
		logic [7:0]  dig[10];
		logic [31:0] v;
		logic [63:0] h, k;
		int          len, n, pos, b, pass;
		len = 0;
		for (pass = 0; pass < 2; pass++) begin
			v = (pass == 0) ? node : idx;
			n = 0;
			do begin
				dig[n] = 8'h30 + v % 10;
				v = v / 10;
				n++;
			end while (v != 0);
			for (b = n - 1; b >= 0; b--) begin
				txt[len] = dig[b];
				len++;
			end
			if (pass == 0) begin
				txt[len] = 8'h3a;
				len++;
			end
		end
		h = 64'h9e3779b97f4a7c15;
		pos = 0;
		while (len - pos >= 8) begin
			k = '0;
			for (b = 0; b < 8; b++) k[8*b +: 8] = txt[pos + b];
			h = absorb(h, k);
			pos += 8;
		end
		if (len > pos) begin
			k = '0;
			for (b = 0; pos + b < len; b++) k[8*b +: 8] = txt[pos + b];
			h = h ^ mix64(k);
		end
		return mix64(h);
	endfunction

	function automatic int member_at(logic [31:0] node);
		for (int i = 0; i < member_num; i++)
			if (members[i] == node) return i;
		return -1;
	endfunction

	task automatic queue_answer(status_t st, logic [31:0] node, logic last);
		ring_answer_t a;
		a.st = st;
		a.node = node;
		a.cnt = member_num[4:0];
		a.last = last;
		answers_due.push_back(a);
	endtask

	task automatic do_add(logic [31:0] node);
		int          v, pos;
		logic [63:0] h;
		v = (vnodes == 0) ? 16 : vnodes;
		if (member_at(node) >= 0) begin
			queue_answer(ST_EXISTS, '0, 1'b1);
		end else if (member_num >= DefMaxMembers || ring_points + v > DefMaxPoints) begin
			queue_answer(ST_FULL, '0, 1'b1);
		end else begin
			members[member_num] = node;
			member_num++;
			for (int i = 0; i < v; i++) begin
				h = vpoint_hash(node, i);
				pos = ring_points;
				while (pos > 0 && ring_hash[pos-1] > h) pos--;
				for (int j = ring_points; j > pos; j--) begin
					ring_hash[j] = ring_hash[j-1];
					ring_owner[j] = ring_owner[j-1];
				end
				ring_hash[pos] = h;
				ring_owner[pos] = node;
				ring_points++;
			end
			queue_answer(ST_OK, '0, 1'b1);
		end
	endtask

	task automatic do_remove(logic [31:0] node);
		int f, w;
		f = member_at(node);
		if (f < 0) begin
			queue_answer(ST_NOT_FOUND, '0, 1'b1);
		end else begin
			for (int i = f; i + 1 < member_num; i++) members[i] = members[i+1];
			member_num--;
			w = 0;
			for (int i = 0; i < ring_points; i++)
				if (ring_owner[i] != node) begin
					ring_hash[w] = ring_hash[i];
					ring_owner[w] = ring_owner[i];
					w++;
				end
			ring_points = w;
			queue_answer(ST_OK, '0, 1'b1);
		end
	endtask

	task automatic do_key(logic [63:0] word, logic [3:0] kb, logic klast, logic [3:0] mw);
		logic [63:0] h;
		logic [31:0] picked[DefMaxReplicas];
		int          target, found, lo, hi, mid, idx;
		bit          dup;
		if (!klast || kb >= 8)
			key_acc = absorb(key_acc, word);
		else if (kb > 0)
			key_acc = key_acc ^ mix64(word & ((64'd1 << (8 * kb)) - 64'd1));
		if (!klast) return;
		h = mix64(key_acc);
		key_acc = HASH_SEED;
		if (ring_points == 0) begin
			queue_answer(ST_EMPTY, '0, 1'b1);
			return;
		end
		target = (replicas == 0) ? 1 : replicas;
		if (target > DefMaxReplicas) target = DefMaxReplicas;
		if (target > mw) target = mw;
		if (target > member_num) target = member_num;
		if (target == 0) begin
			queue_answer(ST_OK, '0, 1'b1);
			return;
		end
		lo = 0;
		hi = ring_points;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (ring_hash[mid] < h) lo = mid + 1;
			else hi = mid;
		end
		if (lo >= ring_points) lo = 0;
		found = 0;
		for (int i = 0; i < ring_points && found < target; i++) begin
			idx = lo + i;
			if (idx >= ring_points) idx -= ring_points;
			dup = 0;
			for (int j = 0; j < found; j++)
				if (picked[j] == ring_owner[idx]) dup = 1;
			if (!dup) begin
				picked[found] = ring_owner[idx];
				found++;
			end
		end
		for (int j = 0; j < found; j++) queue_answer(ST_OK, picked[j], j + 1 == found);
	endtask

	// predict on accepted words, compare results in order
	always @(posedge clk or negedge arst_n) begin
		ring_answer_t a;
		if (!arst_n) begin
			ring_points = 0;
			member_num = 0;
			key_acc = HASH_SEED;
			vnodes = VNODES_RESET;
			replicas = REPLICA_RESET;
			fail_count = 0;
			answers_due.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_VNODES) vnodes = cfg_data;
				else if (cfg_index == CFG_REPLICAS) replicas = cfg_data[3:0];
			end
			if (s_tvalid && s_tready) begin
				case (action_t'(s_tuser))
					ACT_ADD:    do_add(s_tdata[31:0]);
					ACT_REMOVE: do_remove(s_tdata[31:0]);
					ACT_KEY:    do_key(s_tdata[95:32], s_tdata[99:96], s_tlast,
						s_tdata[103:100]);
					default:    ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (answers_due.size() == 0) begin
					$display("%0t: unexpected result st=%0d node=%h cnt=%0d last=%b",
						$time, m_tuser, m_tdata[31:0], m_tdata[36:32], m_tlast);
					fail_count++;
				end else begin
					a = answers_due.pop_front();
					if (m_tuser !== a.st || m_tdata[31:0] !== a.node ||
							m_tdata[36:32] !== a.cnt || m_tlast !== a.last ||
							m_tdata[39:37] !== 3'b0) begin
						$display("%0t: mismatch exp st=%0d node=%h cnt=%0d last=%b",
							$time, a.st, a.node, a.cnt, a.last);
						$display("%0t:          got st=%0d node=%h cnt=%0d last=%b",
							$time, m_tuser, m_tdata[31:0], m_tdata[36:32], m_tlast);
						fail_count++;
					end
				end
			end
			pending = answers_due.size();
		end
	end

endmodule

// ----- tb/sv/tb_consistent_hash_ring.sv -----
`timescale 1ns / 100ps
module tb_consistent_hash_ring;
	import chr_pkg::*;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = '0;
	logic [6:0]   cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// node_id, key_word, key_bytes, max_wanted
	logic [103:0] s_tdata = '0;
	// action
	logic [1:0]   s_tuser = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// replica_node, ring member count, zero fill
	logic [39:0]  m_tdata;
	// status
	logic [2:0]   m_tuser;
	logic         m_tlast;

	int fail_count, pending;
	int send_idle = 6, recv_idle = 58;
	bit hold_go = 0;

	always #5 clk = ~clk;

	consistent_hash_ring u_top (.*);

	chr_ring_checker u_chk (.*);

	// result side readiness, with one long hold-off on request
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				hold_done = 1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready = 1'b0;
			end else begin
				m_tready = ($urandom_range(99) >= recv_idle);
			end
		end
	end

	task automatic put_word(action_t act, logic [31:0] node, logic [63:0] word,
			logic [3:0] kb, logic klast, logic [3:0] mw);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = act;
		s_tdata = {mw, kb, word, node};
		s_tlast = klast;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic write_reg(cfg_index_t idx, logic [6:0] val);
		while (pending != 0) @(negedge clk);
		s_tvalid = 1'b0;
		repeat (100) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [31:0] pick_node();
		if ($urandom_range(9) == 0) return $urandom;
		return $urandom_range(19);
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// mostly whole keys, with adds, removes, stray words and unused codes
	task automatic random_traffic(int n);
		int sel, words;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 55) begin
				words = $urandom_range(2);
				repeat (words)
					put_word(ACT_KEY, $urandom, rnd64(), $urandom, 1'b0, $urandom);
				put_word(ACT_KEY, $urandom, rnd64(), $urandom, 1'b1, $urandom);
			end else if (sel < 75) begin
				put_word(ACT_ADD, pick_node(), rnd64(), $urandom, $urandom, $urandom);
			end else if (sel < 92) begin
				put_word(ACT_REMOVE, pick_node(), rnd64(), $urandom, $urandom, $urandom);
			end else if (sel < 96) begin
				put_word(ACT_KEY, $urandom, rnd64(), $urandom, 1'b0, $urandom);
			end else begin
				put_word(ACT_NONE, $urandom, rnd64(), $urandom, $urandom, $urandom);
				i--;
			end
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty ring, extremes of ids and key lengths, error codes
		put_word(ACT_KEY, '0, '1, 4'd8, 1'b1, 4'd8);
		put_word(ACT_REMOVE, 32'd5, '0, '0, 1'b0, '0);
		put_word(ACT_ADD, 32'd0, '0, '0, 1'b0, '0);
		put_word(ACT_ADD, 32'hffff_ffff, '1, '1, 1'b1, '1);
		put_word(ACT_ADD, 32'd0, '0, '0, 1'b0, '0);
		put_word(ACT_ADD, 32'd1234567890, '0, '0, 1'b0, '0);
		put_word(ACT_KEY, '0, '0, 4'd0, 1'b1, 4'd15);
		put_word(ACT_KEY, '0, '1, 4'd15, 1'b1, 4'd8);
		put_word(ACT_KEY, '0, 64'h0123_4567_89ab_cdef, 4'd3, 1'b1, 4'd0);
		put_word(ACT_KEY, '0, '1, 4'd0, 1'b0, 4'd1);
		put_word(ACT_KEY, '1, 64'h8000_0000_0000_0001, 4'd7, 1'b1, 4'd2);
		put_word(ACT_NONE, '1, '1, '1, 1'b1, '1);
		put_word(ACT_KEY, '0, rnd64(), 4'd1, 1'b1, 4'd3);
		put_word(ACT_REMOVE, 32'hffff_ffff, '0, '0, 1'b0, '0);
		put_word(ACT_REMOVE, 32'hffff_ffff, '0, '0, 1'b0, '0);
		put_word(ACT_KEY, '0, rnd64(), 4'd8, 1'b1, 4'd8);
		random_traffic(60);

		// big vnode count: the table has room for at most four nodes
		write_reg(CFG_VNODES, 7'd64);
		write_reg(CFG_REPLICAS, 4'd8);
		for (int i = 20; i < 26; i++) put_word(ACT_ADD, i, '0, '0, 1'b0, '0);
		random_traffic(30);

		send_idle = 58;
		recv_idle = 6;
		write_reg(CFG_VNODES, 7'd1);
		write_reg(CFG_REPLICAS, 4'd1);
		for (int i = 0; i < 30; i++) put_word(ACT_REMOVE, i, '0, '0, 1'b0, '0);
		for (int i = 0; i < 18; i++) put_word(ACT_ADD, 100 + i, '0, '0, 1'b0, '0);
		random_traffic(45);

		write_reg(CFG_VNODES, 7'd0);
		write_reg(CFG_REPLICAS, 4'd0);
		random_traffic(40);

		send_idle = 0;
		recv_idle = 0;
		write_reg(CFG_VNODES, 7'd127);
		write_reg(CFG_REPLICAS, 4'd15);
		hold_go = 1;
		random_traffic(25);

		write_reg(CFG_VNODES, 7'd5);
		write_reg(CFG_REPLICAS, 4'd4);
		random_traffic(70);

		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (fail_count == 0)
			$display("[consistent_hash_ring] OK");
		else
			$display("[consistent_hash_ring] ERROR");
		$finish;
	end

	initial begin
		#100ms;
		$display("[consistent_hash_ring] ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/chr_pkg.sv
rtl/chr_mix.sv
rtl/consistent_hash_ring.sv
tb/sv/chr_ring_checker.sv
tb/sv/tb_consistent_hash_ring.sv
